>>> hdl/hrhp_pkg.sv
// Shared types and codes for the HTTP response header parser.
// No dependencies; imported by every module of the block.
package hrhp_pkg;

  localparam int ByteW = 8;
  localparam int ClassW = 3;
  localparam int StatusW = 2;

  // Byte classes reported with each result.
  localparam logic [ClassW-1:0] CL_STATUS = 3'd0;
  localparam logic [ClassW-1:0] CL_DELIM  = 3'd1;
  localparam logic [ClassW-1:0] CL_NAME   = 3'd2;
  localparam logic [ClassW-1:0] CL_VALUE  = 3'd3;
  localparam logic [ClassW-1:0] CL_BODY   = 3'd4;
  localparam logic [ClassW-1:0] CL_REJECT = 3'd5;

  // Parse status values.
  localparam logic [StatusW-1:0] ST_PARSING = 2'd0;
  localparam logic [StatusW-1:0] ST_DONE    = 2'd1;
  localparam logic [StatusW-1:0] ST_ERROR   = 2'd2;

  localparam logic [ByteW-1:0] CH_CR    = 8'h0D;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0A;
  localparam logic [ByteW-1:0] CH_SPACE = 8'h20;
  localparam logic [ByteW-1:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic [ClassW-1:0]  cls;
    logic [StatusW-1:0] status;
  } result_t;

  // Each entry holds one or two results; two is set when second holds one.
  typedef struct packed {
    logic    two;
    result_t first;
    result_t second;
  } entry_t;

endpackage

>>> hdl/hrhp_front.sv
// Front end: accepts bytes, runs the parser state machine, and builds a queue entry.
// Depends on hrhp_pkg.
module hrhp_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [hrhp_pkg::ByteW-1:0]    in_byte,
  input  logic                          new_response,
  input  logic                          accept,
  output logic                          entry_valid,
  output hrhp_pkg::entry_t              entry
);
  import hrhp_pkg::*;

  localparam logic [3:0] PH_VER          = 4'd0;
  localparam logic [3:0] PH_VER_DELIM    = 4'd1;
  localparam logic [3:0] PH_STATUS       = 4'd2;
  localparam logic [3:0] PH_STATUS_DELIM = 4'd3;
  localparam logic [3:0] PH_REASON       = 4'd4;
  localparam logic [3:0] PH_HEADERS      = 4'd5;
  localparam logic [3:0] PH_NAME         = 4'd6;
  localparam logic [3:0] PH_NAME_DELIM   = 4'd7;
  localparam logic [3:0] PH_VALUE        = 4'd8;
  localparam logic [3:0] PH_BODY         = 4'd9;
  localparam logic [3:0] PH_ERROR        = 4'd10;

  function automatic logic [StatusW-1:0] status_of(input logic [3:0] ph);
    logic [StatusW-1:0] s;
    if (ph == PH_BODY) begin
      s = ST_DONE;
    end else if (ph >= PH_ERROR) begin
      s = ST_ERROR;
    end else begin
      s = ST_PARSING;
    end
    return s;
  endfunction

  // Expected character of the fixed token of a phase at a position.
  function automatic logic [ByteW-1:0] tok_char(input logic [3:0] ph, input logic [2:0] pos);
    logic [ByteW-1:0] c;
    c = 8'h00;
    if (ph == PH_VER) begin
      unique case (pos)
        3'd0: c = 8'h48;
        3'd1: c = 8'h54;
        3'd2: c = 8'h54;
        3'd3: c = 8'h50;
        3'd4: c = 8'h2F;
        3'd5: c = 8'h31;
        3'd6: c = 8'h2E;
        3'd7: c = 8'h30;
        default: c = 8'h00;
      endcase
    end else if (ph == PH_STATUS) begin
      c = (pos == 3'd0) ? 8'h32 : 8'h30;
    end else begin
      unique case (pos)
        3'd0: c = 8'h4F;
        3'd1: c = 8'h4B;
        3'd2: c = CH_CR;
        default: c = CH_LF;
      endcase
    end
    return c;
  endfunction

  function automatic logic [3:0] tok_len(input logic [3:0] ph);
    logic [3:0] n;
    if (ph == PH_VER) begin
      n = 4'd8;
    end else if (ph == PH_STATUS) begin
      n = 4'd3;
    end else begin
      n = 4'd4;
    end
    return n;
  endfunction

  logic [3:0] phase, phase_next;
  logic [2:0] token_pos, token_pos_next;
  logic       cr_held, cr_held_next;

  logic [3:0]        ph0, ph1, ph2, match_next;
  logic [2:0]        tp0;
  logic              crh0, done_early, emit;
  logic [ClassW-1:0] cls;
  logic [3:0]        pos_inc;
  result_t           res0, res1, res_b;
  logic [1:0]        cnt;

  always_comb begin
    ph0 = new_response ? PH_VER : phase;
    tp0 = new_response ? 3'd0 : token_pos;
    crh0 = new_response ? 1'b0 : cr_held;
    ph1 = ph0;
    res0 = '0;
    res1 = '0;
    res_b = '0;
    cnt = 2'd0;
    done_early = 1'b0;
    cr_held_next = 1'b0;

    // A held CR is resolved against this byte first.
    if (crh0 && (ph0 == PH_HEADERS || ph0 == PH_VALUE)) begin
      if (in_byte == CH_LF) begin
        ph1 = (ph0 == PH_HEADERS) ? PH_BODY : PH_HEADERS;
        res0 = '{data: CH_CR, cls: CL_DELIM, status: ST_PARSING};
        res1 = '{data: in_byte, cls: CL_DELIM, status: status_of(ph1)};
        cnt = 2'd2;
        done_early = 1'b1;
      end else if (ph0 == PH_HEADERS) begin
        ph1 = PH_NAME;
        res0 = '{data: CH_CR, cls: CL_NAME, status: ST_PARSING};
        cnt = 2'd1;
      end else begin
        res0 = '{data: CH_CR, cls: CL_VALUE, status: ST_PARSING};
        cnt = 2'd1;
      end
    end

    // Phases that hand a non-matching byte on to the next phase.
    ph2 = ph1;
    token_pos_next = tp0;
    if (ph1 == PH_VER_DELIM && in_byte != CH_SPACE) begin
      ph2 = PH_STATUS;
      token_pos_next = 3'd0;
    end else if (ph1 == PH_STATUS_DELIM && in_byte != CH_SPACE) begin
      ph2 = PH_REASON;
      token_pos_next = 3'd0;
    end else if (ph1 == PH_HEADERS && in_byte != CH_CR) begin
      ph2 = PH_NAME;
    end else if (ph1 == PH_NAME_DELIM && in_byte != CH_SPACE) begin
      ph2 = PH_VALUE;
    end

    pos_inc = {1'b0, token_pos_next} + 4'd1;
    match_next = ph2;
    if (ph2 == PH_VER) begin
      match_next = PH_VER_DELIM;
    end else if (ph2 == PH_STATUS) begin
      match_next = PH_STATUS_DELIM;
    end else begin
      match_next = PH_HEADERS;
    end

    phase_next = ph2;
    emit = 1'b1;
    cls = CL_REJECT;
    unique case (ph2)
      PH_VER, PH_STATUS, PH_REASON: begin
        if ({1'b0, token_pos_next} < tok_len(ph2) &&
            tok_char(ph2, token_pos_next) == in_byte) begin
          cls = CL_STATUS;
          if (pos_inc >= tok_len(ph2)) begin
            token_pos_next = 3'd0;
            phase_next = match_next;
          end else begin
            token_pos_next = pos_inc[2:0];
          end
        end else begin
          cls = CL_REJECT;
          token_pos_next = 3'd0;
          phase_next = PH_ERROR;
        end
      end
      PH_VER_DELIM, PH_STATUS_DELIM, PH_NAME_DELIM: cls = CL_DELIM;
      PH_HEADERS, PH_VALUE: begin
        if (in_byte == CH_CR) begin
          emit = 1'b0;
          cr_held_next = 1'b1;
        end else begin
          cls = CL_VALUE;
        end
      end
      PH_NAME: begin
        if (in_byte == CH_COLON) begin
          phase_next = PH_NAME_DELIM;
          cls = CL_DELIM;
        end else begin
          cls = CL_NAME;
        end
      end
      PH_BODY: cls = CL_BODY;
      default: begin
        phase_next = PH_ERROR;
        cls = CL_REJECT;
      end
    endcase

    if (done_early) begin
      phase_next = ph1;
      token_pos_next = tp0;
      cr_held_next = 1'b0;
    end else if (emit) begin
      res_b = '{data: in_byte, cls: cls, status: status_of(phase_next)};
      if (cnt == 2'd0) begin
        res0 = res_b;
        cnt = 2'd1;
      end else begin
        res1 = res_b;
        cnt = 2'd2;
      end
    end
  end

  assign entry_valid = accept && (cnt != 2'd0);
  assign entry = '{two: (cnt == 2'd2), first: res0, second: res1};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_VER;
      token_pos <= 3'd0;
      cr_held <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      token_pos <= token_pos_next;
      cr_held <= cr_held_next;
    end
  end

endmodule

>>> hdl/hrhp_queue.sv
// Short register queue that decouples the parser front end from the result drain.
// Depends on hrhp_pkg.
module hrhp_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  hrhp_pkg::entry_t wr_entry,
  output logic             full,
  input  logic             rd_en,
  output logic             q_empty,
  output hrhp_pkg::entry_t rd_entry
);
  import hrhp_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  entry_t slots [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic do_wr, do_rd;

  assign full = (count == CntW'(DEPTH));
  assign q_empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !q_empty;
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/hrhp_back.sv
// Back end: drains queue entries one result per beat and marks the final one.
// Depends on hrhp_pkg.
module hrhp_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  hrhp_pkg::entry_t             head,
  output logic                         q_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [hrhp_pkg::ByteW-1:0]   out_byte,
  output logic [hrhp_pkg::ClassW-1:0]  byte_class,
  output logic [hrhp_pkg::StatusW-1:0] parse_status,
  output logic                         last
);
  import hrhp_pkg::*;

  // Set while the second result of the head entry is on the outputs.
  logic    second;
  result_t cur;
  logic    take;

  assign cur = second ? head.second : head.first;
  assign empty = q_empty;
  assign out_byte = cur.data;
  assign byte_class = cur.cls;
  assign parse_status = cur.status;
  assign last = second || !head.two;
  assign take = pop && !q_empty;
  assign q_pop = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (take) begin
      second <= !last;
    end
  end

endmodule

>>> hdl/http_response_header_parser_top.sv
// HTTP response header parser: one byte per cycle in while the queue is not full, one result per beat out.
// A byte's results are written into the entry queue and reach the outputs once earlier entries have drained.
// Throughput: one byte per cycle while the queue is not full, limited to one result per beat at the output;
// bytes that give two results drain over two beats through the entry queue.
// Reset (rst, synchronous) returns the parser to the version token and empties the queue.
module http_response_header_parser_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [hrhp_pkg::ByteW-1:0]   in_byte,
  input  logic                         new_response,
  input  logic                         push,
  output logic                         full,
  output logic [hrhp_pkg::ByteW-1:0]   out_byte,
  output logic [hrhp_pkg::ClassW-1:0]  byte_class,
  output logic [hrhp_pkg::StatusW-1:0] parse_status,
  output logic                         last,
  output logic                         empty,
  input  logic                         pop
);
  import hrhp_pkg::*;

  logic   accept, entry_valid, q_empty, q_pop;
  entry_t entry, head;

  assign accept = push && !full;

  hrhp_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_byte      (in_byte),
    .new_response (new_response),
    .accept       (accept),
    .entry_valid  (entry_valid),
    .entry        (entry)
  );

  hrhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (entry_valid),
    .wr_entry (entry),
    .full     (full),
    .rd_en    (q_pop),
    .q_empty  (q_empty),
    .rd_entry (head)
  );

  hrhp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (head),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .byte_class   (byte_class),
    .parse_status (parse_status),
    .last         (last)
  );

endmodule

>>> test/http_response_header_parser_top_tb.sv
`timescale 1ns / 100ps
// Testbench for http_response_header_parser_top: byte stream in, classified beats out.
// Depends on hrhp_pkg and the parser RTL; predicts every beat and checks it in order.
module http_response_header_parser_top_tb;
  import hrhp_pkg::*;

  typedef enum logic [3:0] {
    PH_VERSION, PH_VER_GAP, PH_CODE, PH_CODE_GAP, PH_REASON,
    PH_LINE_START, PH_NAME, PH_NAME_GAP, PH_VALUE, PH_BODY, PH_ERROR
  } phase_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             restart;
  } stream_byte_t;

  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic [ClassW-1:0]  cls;
    logic [StatusW-1:0] status;
    logic               last;
  } beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic [ByteW-1:0]   in_byte = '0;
  logic               new_response = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [ByteW-1:0]   out_byte;
  logic [ClassW-1:0]  byte_class;
  logic [StatusW-1:0] parse_status;
  logic               last;
  logic               empty;
  logic               pop = 1'b0;

  stream_byte_t byte_queue[$];
  beat_t        expected_beats[$];
  logic [7:0]   draft[$];
  stream_byte_t next_byte;
  beat_t        want;
  int           bytes_planned = 0;
  int           bytes_taken = 0;
  int           errors = 0;

  // Predicted parser state.
  phase_t     phase = PH_VERSION;
  logic [2:0] tok_pos = '0;
  logic       cr_held = 1'b0;

  http_response_header_parser_top DUT (
    .clk(clk), .rst(rst), .in_byte(in_byte), .new_response(new_response),
    .push(push), .full(full), .out_byte(out_byte), .byte_class(byte_class),
    .parse_status(parse_status), .last(last), .empty(empty), .pop(pop)
  );

  always #5 clk = ~clk;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic logic [StatusW-1:0] status_of(input phase_t ph);
    if (ph == PH_BODY) return ST_DONE;
    if (ph >= PH_ERROR) return ST_ERROR;
    return ST_PARSING;
  endfunction

  // Fixed text that each token phase must match; the reason ends in CR LF.
  function automatic string token_of(input phase_t ph);
    case (ph)
      PH_VERSION: return "HTTP/1.0";
      PH_CODE:    return "200";
      default:    return "OK\015\012";
    endcase
  endfunction

  task automatic emit(input logic [ByteW-1:0] b, input logic [ClassW-1:0] cls);
    beat_t r;
    r.data = b;
    r.cls = cls;
    r.status = status_of(phase);
    r.last = 1'b0;
    expected_beats.push_back(r);
  endtask

  task automatic match_token(input logic [ByteW-1:0] b, output logic [ClassW-1:0] cls);
    string tok;
    tok = token_of(phase);
    if (tok_pos < tok.len() && tok[tok_pos] == b) begin
      cls = CL_STATUS;
      // Token phases are each followed by the phase that comes after them.
      if (tok_pos + 1 >= tok.len()) begin
        tok_pos = '0;
        phase = phase_t'(phase + 1);
      end else begin
        tok_pos = tok_pos + 3'd1;
      end
    end else begin
      tok_pos = '0;
      phase = PH_ERROR;
      cls = CL_REJECT;
    end
  endtask

  task automatic classify(input logic [ByteW-1:0] b, output logic held,
                          output logic [ClassW-1:0] cls);
    logic done;
    held = 1'b0;
    cls = CL_REJECT;
    done = 1'b0;
    while (!done) begin
      done = 1'b1;
      case (phase)
        PH_VERSION, PH_CODE, PH_REASON: match_token(b, cls);
        PH_VER_GAP, PH_CODE_GAP: begin
          if (b == CH_SPACE) begin
            cls = CL_DELIM;
          end else begin
            phase = phase_t'(phase + 1);
            tok_pos = '0;
            done = 1'b0;
          end
        end
        PH_LINE_START: begin
          if (b == CH_CR) begin
            cr_held = 1'b1;
            held = 1'b1;
          end else begin
            phase = PH_NAME;
            done = 1'b0;
          end
        end
        PH_NAME: begin
          if (b == CH_COLON) begin
            phase = PH_NAME_GAP;
            cls = CL_DELIM;
          end else begin
            cls = CL_NAME;
          end
        end
        PH_NAME_GAP: begin
          if (b == CH_SPACE) begin
            cls = CL_DELIM;
          end else begin
            phase = PH_VALUE;
            done = 1'b0;
          end
        end
        PH_VALUE: begin
          if (b == CH_CR) begin
            cr_held = 1'b1;
            held = 1'b1;
          end else begin
            cls = CL_VALUE;
          end
        end
        PH_BODY: cls = CL_BODY;
        default: begin
          phase = PH_ERROR;
          cls = CL_REJECT;
        end
      endcase
    end
  endtask

  // Works out the beats caused by one accepted byte and queues them.
  task automatic parse_byte(input logic [ByteW-1:0] b, input logic restart);
    int          first;
    logic        held;
    logic        line_done;
    logic [ClassW-1:0] cls;
    first = expected_beats.size();
    line_done = 1'b0;
    if (restart) begin
      phase = PH_VERSION;
      tok_pos = '0;
      cr_held = 1'b0;
    end
    if (cr_held) begin
      cr_held = 1'b0;
      if (phase == PH_LINE_START || phase == PH_VALUE) begin
        if (b == CH_LF) begin
          emit(CH_CR, CL_DELIM);
          phase = (phase == PH_LINE_START) ? PH_BODY : PH_LINE_START;
          emit(b, CL_DELIM);
          line_done = 1'b1;
        end else if (phase == PH_LINE_START) begin
          phase = PH_NAME;
          emit(CH_CR, CL_NAME);
        end else begin
          emit(CH_CR, CL_VALUE);
        end
      end
    end
    if (!line_done) begin
      classify(b, held, cls);
      if (!held) emit(b, cls);
    end
    if (expected_beats.size() > first)
      expected_beats[expected_beats.size() - 1].last = 1'b1;
  endtask

  // Idles about a quarter of the time, except for a stretch in the middle of the run.
  function automatic logic take_break();
    if (bytes_taken >= 400 && bytes_taken < 700) return 1'b0;
    return $urandom_range(99) < 24;
  endfunction

  task automatic add_byte(input logic [ByteW-1:0] b, input logic restart);
    stream_byte_t s;
    s.data = b;
    s.restart = restart;
    byte_queue.push_back(s);
    bytes_planned++;
  endtask

  task automatic add_text(input string s, input logic restart);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], restart && i == 0);
  endtask

  task automatic draft_text(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endtask

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == CH_COLON) c = "n";
    return c;
  endfunction

  // A well-formed response with random content, sometimes damaged or cut short.
  task automatic queue_response();
    int cut;
    int pick;
    draft = {};
    draft_text("HTTP/1.0");
    repeat ($urandom_range(0, 3)) draft.push_back(CH_SPACE);
    draft_text("200");
    repeat ($urandom_range(0, 3)) draft.push_back(CH_SPACE);
    draft_text("OK");
    draft.push_back(CH_CR);
    draft.push_back(CH_LF);
    repeat ($urandom_range(0, 3)) begin
      repeat ($urandom_range(1, 5)) draft.push_back(name_char());
      draft.push_back(CH_COLON);
      repeat ($urandom_range(0, 2)) draft.push_back(CH_SPACE);
      repeat ($urandom_range(0, 5)) draft.push_back(8'($urandom_range(0, 255)));
      draft.push_back(CH_CR);
      draft.push_back(CH_LF);
    end
    draft.push_back(CH_CR);
    draft.push_back(CH_LF);
    repeat ($urandom_range(0, 6)) draft.push_back(8'($urandom_range(0, 255)));
    pick = $urandom_range(99);
    if (pick < 12) begin
      draft[$urandom_range(0, draft.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (pick < 24) begin
      // Often cut right after a header CR so that the restart finds a CR held.
      cut = $urandom_range(1, draft.size() - 1);
      for (int i = 17; i < draft.size(); i++) begin
        if (draft[i] == CH_CR && $urandom_range(0, 1)) begin
          cut = i + 1;
          break;
        end
      end
      while (draft.size() > cut) void'(draft.pop_back());
    end
    for (int i = 0; i < draft.size(); i++) add_byte(draft[i], i == 0);
  endtask

  // Sender: holds a byte on the inputs until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
      in_byte <= '0;
      new_response <= 1'b0;
    end else begin
      if (push && !full) begin
        parse_byte(in_byte, new_response);
        bytes_taken++;
      end
      if (!(push && full)) begin
        if (byte_queue.size() != 0 && !take_break()) begin
          next_byte = byte_queue.pop_front();
          push <= 1'b1;
          in_byte <= next_byte.data;
          new_response <= next_byte.restart;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each popped beat against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          flag_error($sformatf("beat with nothing expected: byte %02h class %0d",
                               out_byte, byte_class));
        end else begin
          want = expected_beats.pop_front();
          if (out_byte !== want.data)
            flag_error($sformatf("out_byte %02h, expected %02h", out_byte, want.data));
          if (byte_class !== want.cls)
            flag_error($sformatf("byte_class %0d, expected %0d (byte %02h)",
                                 byte_class, want.cls, want.data));
          if (parse_status !== want.status)
            flag_error($sformatf("parse_status %0d, expected %0d (byte %02h)",
                                 parse_status, want.status, want.data));
          if (last !== want.last)
            flag_error($sformatf("last %0b, expected %0b (byte %02h)",
                                 last, want.last, want.data));
        end
      end
      pop <= !take_break();
    end
  end

  initial begin
    // Status line with no spaces, a line that starts with a released CR and
    // carries a CR in its name, a value that holds a CR twice, then the end
    // of the headers and body bytes at both extremes.
    add_text("HTTP/1.0200OK", 1'b1);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_LF, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_COLON, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_LF, 1'b0);
    add_byte(CH_CR, 1'b0);
    add_byte(CH_LF, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    // A restart straight into a bad version byte, then a byte in the error state.
    add_byte("X", 1'b1);
    add_byte("H", 1'b0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Let the directed beats drain completely before the random traffic starts.
    while (byte_queue.size() != 0 || push || expected_beats.size() != 0) @(posedge clk);

    while (bytes_planned < 1230) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8))
          add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        queue_response();
      end
    end

    while (byte_queue.size() != 0 || push || expected_beats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("Timeout with %0d beats still expected", expected_beats.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> filelist.f
hdl/hrhp_pkg.sv
hdl/hrhp_front.sv
hdl/hrhp_queue.sv
hdl/hrhp_back.sv
hdl/http_response_header_parser_top.sv
test/http_response_header_parser_top_tb.sv
